// ===== rtl/core/nfha_pkg.sv =====
// Package with constants and types shared by the next-fit heap allocator.
`timescale 1ns / 1ps
package nfha_pkg;
   localparam int HEAP_UNITS = 4096;
   localparam int UNIT_W = $clog2(HEAP_UNITS);
   localparam int CNT_W = UNIT_W + 1;
   localparam int SIZE_W = 16;
   localparam int HDR_W = SIZE_W + 1;
   localparam int OFF_W = 15;
   localparam logic [15:0] HEAP_BYTES_RESET = 16'd32768;
   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE = 1'b1;
   localparam logic [1:0] REG_HEAP_BYTES = 2'd0;

   typedef struct packed {
      logic func;
      logic [15:0] request_bytes;
      logic [OFF_W-1:0] block_offset;
   } req_type;

   typedef struct packed {
      logic ok;
      logic [OFF_W-1:0] payload_offset;
   } rsp_type;
endpackage

// ===== rtl/core/nfha_if.sv =====
// Valid/ready channel interface carrying one request or response payload.
`timescale 1ns / 1ps
interface nfha_req_if;
   import nfha_pkg::*;
   logic valid;
   logic ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface nfha_rsp_if;
   import nfha_pkg::*;
   logic valid;
   logic ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/next_fit_heap_allocator.sv =====
// Top level of the next-fit heap allocator with header memory and walk sequencer.
`timescale 1ns / 1ps
// An allocation reads headers from the rover until one fits or the walk comes back to the
// rover; a free merges the freed header with the free headers that follow it, and an
// invalid offset is ignored.
// Throughput: one request at a time; the next is accepted the cycle after the response is taken.
// Reset, or a write of heap_bytes, starts a clearing pass over the header memory, during
// which no request is accepted. heap_bytes resets to 32768.
module next_fit_heap_allocator (
   input  logic clock,
   input  logic reset,
   nfha_req_if.sink req,
   nfha_rsp_if.source rsp,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [2:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   import nfha_pkg::*;

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE = 4'd1;
   localparam logic [3:0] ST_A_RD = 4'd2;
   localparam logic [3:0] ST_A_CHK = 4'd3;
   localparam logic [3:0] ST_A_WR = 4'd4;
   localparam logic [3:0] ST_F_RD = 4'd5;
   localparam logic [3:0] ST_F_CLR = 4'd6;
   localparam logic [3:0] ST_F_NRD = 4'd7;
   localparam logic [3:0] ST_F_CHK = 4'd8;
   localparam logic [3:0] ST_F_WR = 4'd9;
   localparam logic [3:0] ST_RESP = 4'd10;

   logic [HDR_W-1:0] mem [HEAP_UNITS];
   logic [HDR_W-1:0] rd_data;
   logic [UNIT_W-1:0] rd_addr, wr_addr;
   logic [HDR_W-1:0] wr_data;
   logic wr_en;

   logic [3:0] state_ff, state_in;
   logic [15:0] heap_bytes_ff, heap_bytes_in;
   logic [CNT_W-1:0] units_ff, units_in;
   logic [UNIT_W-1:0] rover_ff, rover_in;
   logic [UNIT_W-1:0] at_ff, at_in;
   logic [UNIT_W-1:0] hdr_ff, hdr_in;
   logic [CNT_W-1:0] steps_ff, steps_in;
   logic [SIZE_W-1:0] need_ff, need_in;
   logic [SIZE_W-1:0] acc_ff, acc_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic cfg_wr;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end

   assign cfg_wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_HEAP_BYTES[0]) ? {16'd0, heap_bytes_ff} : 32'd0;
   assign req.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data = rsp_ff;

   function automatic logic [CNT_W-1:0] units_of(input logic [15:0] b);
      logic [12:0] u;
      begin
         u = b[15:3];
         if (u < 13'd2) u = 13'd2;
         if ({4'd0, u} > 17'(HEAP_UNITS)) u = 13'(HEAP_UNITS);
         units_of = CNT_W'(u);
      end
   endfunction

   // Next header address, widened so that running past the heap end is visible.
   logic [SIZE_W:0] nxt_sum;
   logic nxt_out;
   logic [UNIT_W-1:0] walk_nxt;
   assign nxt_sum = (SIZE_W+1)'(at_ff) + (SIZE_W+1)'(rd_data[SIZE_W-1:0]) + 1'b1;
   assign nxt_out = nxt_sum >= (SIZE_W+1)'(units_ff);
   assign walk_nxt = nxt_out ? '0 : UNIT_W'(nxt_sum);

   // Header of the split-off remainder.
   logic [SIZE_W:0] rest_sum;
   assign rest_sum = (SIZE_W+1)'(at_ff) + {1'b0, need_ff} + 17'd1;

   // The header after the merged block is always the freed header plus its merged size plus one.
   logic [SIZE_W:0] fnxt_sum;
   logic fnxt_out;
   assign fnxt_sum = (SIZE_W+1)'(hdr_ff) + {1'b0, acc_ff} + 17'd1;
   assign fnxt_out = fnxt_sum >= (SIZE_W+1)'(units_ff);

   always_comb begin
      state_in = state_ff;
      heap_bytes_in = heap_bytes_ff;
      units_in = units_ff;
      rover_in = rover_ff;
      at_in = at_ff;
      hdr_in = hdr_ff;
      steps_in = steps_ff;
      need_in = need_ff;
      acc_in = acc_ff;
      size_in = size_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      rd_addr = at_ff;
      wr_en = 1'b0;
      wr_addr = at_ff;
      wr_data = '0;
      if (rsp_valid_ff && rsp.ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            wr_addr = at_ff;
            wr_data = (at_ff == '0) ? HDR_W'(units_ff - 1'b1) : '0;
            at_in = at_ff + 1'b1;
            if (at_ff == UNIT_W'(HEAP_UNITS - 1)) begin
               state_in = ST_IDLE;
               at_in = '0;
            end
         end
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               steps_in = '0;
               if (req.data.func == FUNC_ALLOC) begin
                  need_in = SIZE_W'(({1'b0, req.data.request_bytes} + 17'd7) >> 3);
                  at_in = ({1'b0, rover_ff} >= units_ff) ? '0 : rover_ff;
                  state_in = ST_A_RD;
               end else begin
                  hdr_in = UNIT_W'(req.data.block_offset[OFF_W-1:3] - 1'b1);
                  rsp_in.ok = 1'b1;
                  rsp_in.payload_offset = '0;
                  if (req.data.block_offset[OFF_W-1:3] == '0 ||
                      {1'b0, req.data.block_offset[OFF_W-1:3]} > 13'(units_ff)) begin
                     state_in = ST_RESP;
                  end else begin
                     state_in = ST_F_RD;
                  end
               end
            end
         end
         ST_A_RD: begin
            rd_addr = at_ff;
            state_in = ST_A_CHK;
         end
         ST_A_CHK: begin
            if (!rd_data[SIZE_W] &&
                {1'b0, rd_data[SIZE_W-1:0]} > {1'b0, need_ff} + 17'd1) begin
               size_in = rd_data[SIZE_W-1:0];
               state_in = ST_A_WR;
            end else begin
               at_in = walk_nxt;
               rd_addr = walk_nxt;
               steps_in = steps_ff + 1'b1;
               if (walk_nxt == rover_ff || steps_ff >= units_ff) begin
                  rsp_in.ok = 1'b0;
                  rsp_in.payload_offset = '0;
                  state_in = ST_RESP;
               end
            end
         end
         ST_A_WR: begin
            // Two writes: the used header now, the remainder header next cycle.
            wr_en = 1'b1;
            wr_addr = at_ff;
            wr_data = {1'b1, need_ff};
            rover_in = UNIT_W'(rest_sum);
            rsp_in.ok = 1'b1;
            rsp_in.payload_offset = OFF_W'({at_ff + 1'b1, 3'b000});
            acc_in = size_ff - need_ff - 16'd1;
            hdr_in = UNIT_W'(rest_sum);
            state_in = ST_F_WR;
         end
         ST_F_RD: begin
            rd_addr = hdr_ff;
            state_in = ST_F_CLR;
         end
         ST_F_CLR: begin
            acc_in = rd_data[SIZE_W-1:0];
            state_in = ST_F_NRD;
         end
         ST_F_NRD: begin
            if (fnxt_out) begin
               state_in = ST_F_WR;
            end else begin
               // The rover moves back even when the header it sits on stays allocated.
               if (UNIT_W'(fnxt_sum) == rover_ff) rover_in = hdr_ff;
               rd_addr = UNIT_W'(fnxt_sum);
               state_in = ST_F_CHK;
            end
         end
         ST_F_CHK: begin
            if (rd_data[SIZE_W]) begin
               state_in = ST_F_WR;
            end else begin
               acc_in = acc_ff + 16'd1 + rd_data[SIZE_W-1:0];
               state_in = ST_F_NRD;
            end
         end
         ST_F_WR: begin
            wr_en = 1'b1;
            wr_addr = hdr_ff;
            wr_data = {1'b0, acc_ff};
            state_in = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      if (cfg_wr && csr_paddr[2] == REG_HEAP_BYTES[0]) begin
         heap_bytes_in = csr_pwdata[15:0];
         units_in = units_of(csr_pwdata[15:0]);
         rover_in = '0;
         at_in = '0;
         state_in = ST_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         heap_bytes_ff <= HEAP_BYTES_RESET;
         units_ff <= units_of(HEAP_BYTES_RESET);
         rover_ff <= '0;
         at_ff <= '0;
         rsp_valid_ff <= 1'b0;
         steps_ff <= '0;
      end else begin
         state_ff <= state_in;
         heap_bytes_ff <= heap_bytes_in;
         units_ff <= units_in;
         rover_ff <= rover_in;
         rsp_valid_ff <= rsp_valid_in;
         steps_ff <= steps_in;
         at_ff <= at_in;
      end
      hdr_ff <= hdr_in;
      need_ff <= need_in;
      acc_ff <= acc_in;
      size_ff <= size_in;
      rsp_ff <= rsp_in;
   end

   assert property (@(posedge clock) disable iff (reset) rsp_valid_ff |-> !req.ready)
      else $error("request accepted while a response is pending");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req.ready)
      else $error("request accepted during clearing pass");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp.ready) |=> rsp_valid_ff)
      else $error("response dropped before it was taken");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> ({1'b0, rover_ff} < units_ff))
      else $error("rover outside heap");
endmodule

// ===== dv/tb_next_fit_heap_allocator.sv =====
// Self-checking testbench for the next-fit heap allocator with its own heap predictor.
`timescale 1ns / 1ps
module tb_next_fit_heap_allocator;
   import nfha_pkg::*;

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [2:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic csr_pready;

   nfha_req_if req_if ();
   nfha_rsp_if rsp_if ();

   next_fit_heap_allocator u_top (
      .clock(clock),
      .reset(reset),
      .req(req_if.sink),
      .rsp(rsp_if.source),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // Predicted heap: headers, rover and usable unit count.
   logic [HDR_W-1:0] hdr_mem [HEAP_UNITS];
   int unsigned heap_units;
   int unsigned rover;

   req_type request_q [$];
   rsp_type expected_rsp_q [$];
   int unsigned live_offsets [$];
   int errors;
   int unsigned send_gap;
   int unsigned recv_stall;
   bit send_gaps_on;
   bit recv_stalls_on;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #1_000_000_000;
      $display("status: fail");
      $finish;
   end

   task automatic report(input string what, input int unsigned got, input int unsigned want);
      $display("mismatch %s: got %0d, expected %0d (t=%0t)", what, got, want, $realtime);
      errors++;
   endtask

   function automatic void rebuild_heap(input logic [15:0] bytes);
      int unsigned u;
      u = bytes / 8;
      if (u < 2) u = 2;
      if (u > HEAP_UNITS) u = HEAP_UNITS;
      heap_units = u;
      foreach (hdr_mem[i]) hdr_mem[i] = '0;
      hdr_mem[0] = HDR_W'(u - 1);
      rover = 0;
   endfunction

   function automatic rsp_type heap_alloc(input logic [15:0] bytes);
      rsp_type r;
      int unsigned need, at, steps, size, rest;
      logic [HDR_W-1:0] h;
      r = '0;
      need = (int'(bytes) + 7) / 8;
      at = rover;
      steps = 0;
      if (at >= heap_units) at = 0;
      forever begin
         h = hdr_mem[at];
         if (!h[SIZE_W] && h[SIZE_W-1:0] > need + 1) break;
         at = at + h[SIZE_W-1:0] + 1;
         if (at >= heap_units) at = 0;
         if (at == rover) return r;
         steps++;
         if (steps > heap_units) return r;
      end
      size = hdr_mem[at][SIZE_W-1:0];
      rest = (at + 1 + need) % HEAP_UNITS;
      hdr_mem[rest] = {1'b0, 16'(size - need - 1)};
      hdr_mem[at] = {1'b1, 16'(need)};
      rover = rest;
      r.ok = 1'b1;
      r.payload_offset = OFF_W'((at + 1) * 8);
      return r;
   endfunction

   function automatic rsp_type heap_free(input logic [OFF_W-1:0] off);
      rsp_type r;
      int unsigned hdr, cur, nxt;
      r = '0;
      r.ok = 1'b1;
      if (off / 8 == 0) return r;
      hdr = off / 8 - 1;
      if (hdr >= heap_units) return r;
      hdr_mem[hdr][SIZE_W] = 1'b0;
      cur = hdr;
      for (int unsigned s = 0; s < heap_units; s++) begin
         nxt = cur + hdr_mem[cur][SIZE_W-1:0] + 1;
         if (nxt >= heap_units) break;
         // The rover moves back even when the header it sits on stays allocated.
         if (nxt == rover) rover = hdr;
         if (hdr_mem[nxt][SIZE_W]) break;
         hdr_mem[hdr] = {1'b0, 16'(hdr_mem[hdr][SIZE_W-1:0] + 1 + hdr_mem[nxt][SIZE_W-1:0])};
         cur = nxt;
      end
      return r;
   endfunction

   task automatic queue_request(input logic func, input logic [15:0] bytes,
                                input logic [OFF_W-1:0] off);
      req_type q;
      rsp_type r;
      q.func = func;
      q.request_bytes = bytes;
      q.block_offset = off;
      if (func == FUNC_ALLOC) begin
         r = heap_alloc(bytes);
         if (r.ok) live_offsets.push_back(r.payload_offset);
      end else begin
         r = heap_free(off);
         foreach (live_offsets[i])
            if (live_offsets[i] == off) begin
               live_offsets.delete(i);
               break;
            end
      end
      request_q.push_back(q);
      expected_rsp_q.push_back(r);
   endtask

   task automatic drain();
      while (request_q.size() != 0 || req_if.valid || expected_rsp_q.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_heap_bytes(input logic [15:0] bytes);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= 3'(REG_HEAP_BYTES * 4);
      csr_pwdata <= {16'd0, bytes};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      rebuild_heap(bytes);
      live_offsets.delete();
   endtask

   task automatic run_phase(input logic [15:0] bytes, input int count);
      int unsigned pick, span;
      write_heap_bytes(bytes);
      send_gaps_on = $urandom_range(0, 3) != 0;
      recv_stalls_on = $urandom_range(0, 3) != 0;
      span = bytes / 4 + 8;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 6)
            queue_request(FUNC_ALLOC, 16'($urandom_range(0, 65535)), 15'($urandom));
         else if (pick < 10)
            queue_request(FUNC_FREE, 16'($urandom), 15'($urandom_range(0, 32767)));
         else if (pick < 50 && live_offsets.size() != 0)
            queue_request(FUNC_FREE, 16'($urandom),
                          15'(live_offsets[$urandom_range(0, live_offsets.size() - 1)]
                              | $urandom_range(0, 7)));
         else
            queue_request(FUNC_ALLOC, 16'($urandom_range(0, span)), 15'($urandom));
      end
      drain();
   endtask

   // Request driver.
   always @(posedge clock) begin
      int unsigned gap;
      if (reset) begin
         req_if.valid <= 1'b0;
         send_gap <= 0;
      end else if (req_if.valid && req_if.ready) begin
         void'(request_q.pop_front());
         gap = send_gaps_on ? $urandom_range(0, 5) : 0;
         if (gap != 0) begin
            send_gap <= gap - 1;
            req_if.valid <= 1'b0;
         end else if (request_q.size() != 0) begin
            req_if.data <= request_q[0];
         end else begin
            req_if.valid <= 1'b0;
         end
      end else if (!req_if.valid) begin
         if (send_gap != 0) begin
            send_gap <= send_gap - 1;
         end else if (request_q.size() != 0) begin
            req_if.valid <= 1'b1;
            req_if.data <= request_q[0];
         end
      end
   end

   // Response monitor and checker.
   always @(posedge clock) begin
      rsp_type want;
      int unsigned stall;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         recv_stall <= 0;
      end else if (rsp_if.valid && rsp_if.ready) begin
         if (expected_rsp_q.size() == 0) begin
            report("unexpected response", rsp_if.data.ok, 0);
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_if.data.ok !== want.ok) report("ok", rsp_if.data.ok, want.ok);
            if (rsp_if.data.payload_offset !== want.payload_offset)
               report("payload_offset", rsp_if.data.payload_offset, want.payload_offset);
         end
         stall = recv_stalls_on ? $urandom_range(0, 5) : 0;
         if (stall != 0) begin
            recv_stall <= stall;
            rsp_if.ready <= 1'b0;
         end
      end else if (!rsp_if.ready) begin
         if (recv_stall > 1) recv_stall <= recv_stall - 1;
         else rsp_if.ready <= 1'b1;
      end
   end

   initial begin
      errors = 0;
      send_gaps_on = 1'b1;
      recv_stalls_on = 1'b1;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.data = '0;
      rsp_if.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      rebuild_heap(HEAP_BYTES_RESET);
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed requests on the reset heap.
      queue_request(FUNC_ALLOC, 16'd0, 15'd0);
      queue_request(FUNC_ALLOC, 16'd1, 15'h7FFF);
      queue_request(FUNC_ALLOC, 16'd8, 15'd0);
      queue_request(FUNC_ALLOC, 16'd65535, 15'd0);
      queue_request(FUNC_ALLOC, 16'd32768, 15'd0);
      queue_request(FUNC_ALLOC, 16'd100, 15'd0);
      queue_request(FUNC_ALLOC, 16'd24, 15'd0);
      queue_request(FUNC_FREE, 16'hFFFF, 15'd0);
      queue_request(FUNC_FREE, 16'd0, 15'd7);
      queue_request(FUNC_FREE, 16'd0, 15'd24);
      // Freeing an offset inside an allocated block rather than at its start.
      queue_request(FUNC_FREE, 16'd0, 15'd56);
      queue_request(FUNC_FREE, 16'd0, 15'd16);
      queue_request(FUNC_ALLOC, 16'd32000, 15'd0);
      queue_request(FUNC_ALLOC, 16'd400, 15'd0);
      queue_request(FUNC_FREE, 16'd0, 15'd8);
      queue_request(FUNC_FREE, 16'd0, 15'h7FFF);
      drain();

      // A two-unit heap can never satisfy an allocation.
      write_heap_bytes(16'd16);
      queue_request(FUNC_ALLOC, 16'd0, 15'd0);
      queue_request(FUNC_FREE, 16'd0, 15'd8);
      queue_request(FUNC_FREE, 16'd0, 15'd16);
      queue_request(FUNC_FREE, 16'd0, 15'd2000);
      drain();

      run_phase(16'd0, 30);
      run_phase(16'd24, 40);
      run_phase(16'd128, 250);
      run_phase(16'd512, 400);
      run_phase(16'd2048, 510);
      run_phase(16'($urandom_range(16, 4096)), 150);
      run_phase(16'($urandom_range(16, 65535)), 150);
      run_phase(16'd32768, 150);

      repeat (50) @(posedge clock);
      if (errors == 0 && expected_rsp_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule

// ===== files.f =====
rtl/core/nfha_pkg.sv
rtl/core/nfha_if.sv
rtl/core/next_fit_heap_allocator.sv
dv/tb_next_fit_heap_allocator.sv
